/* hw/rtl/icda_pkg.sv */
package icda_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_CHANNELS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECIMATION   = 8'd1;

    localparam int CFG_DATA_W   = 11;
    localparam int NUM_CH_CFG_W = 11;
    localparam int DEC_CFG_W    = 7;

    // field widths
    localparam int SAMPLE_W  = 32;
    localparam int OUT_CH_W  = 10;
    localparam int AVG_W     = 32;
    localparam int M_TDATA_W = 48;

    // per-channel running sum wraps at this width
    localparam int SUM_W = 38;
    // 2*sum + d, signed
    localparam int NUM_W = SUM_W + 2;
    // magnitude of the numerator
    localparam int MAG_W = SUM_W + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_FIN
    } state_t;

endpackage

/* hw/rtl/icda_divider.sv */
module icda_divider #(
    parameter int DVW = 10
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [icda_pkg::MAG_W-1:0] dividend,
    input  logic [DVW-1:0]           divisor,
    output logic                     done,
    output logic [icda_pkg::MAG_W-1:0] quotient
);

    localparam int CNT_W = $clog2(icda_pkg::MAG_W + 1);

    logic [DVW-1:0]              rem_reg;
    logic [icda_pkg::MAG_W-1:0]  quo_reg;
    logic [DVW-1:0]              div_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;

    logic [DVW:0]                shifted;
    logic                        fits;

    // one quotient bit per cycle, restoring
    always_comb begin
        shifted = {rem_reg, quo_reg[icda_pkg::MAG_W-1]};
        fits    = (shifted >= {1'b0, div_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(icda_pkg::MAG_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= DVW'(shifted - {1'b0, div_reg});
            end else begin
                rem_reg <= shifted[DVW-1:0];
            end
            quo_reg <= {quo_reg[icda_pkg::MAG_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* hw/rtl/interleaved_channel_decimating_averager_top.sv */
// channel  | direction | beat payload                                   | handshake
// s_       | in        | tdata[31:0] sample_word                        | s_tvalid / s_tready
// m_       | out       | tdata[9:0] channel, [41:10] average; tlast     | m_tvalid / m_tready
// cfg_     | in        | cfg_index register, cfg_data value             | cfg_valid / cfg_ready
//
// a word outside the last frame of a group passes through accept and sum read-modify-write
// a word in the last frame continues through the divider and the final state; the shared
// restoring divider produces one quotient bit per cycle, then the result is saturated and
// registered
// s_tready is high only while the sequencer is idle; a stalled m_ side holds the
// sequencer in its final state until the output register is free
// aresetn is synchronous; the sum memory is not cleared, the first frame of a group
// overwrites each entry
module interleaved_channel_decimating_averager_top #(
    parameter int MAX_CHANNELS   = 1024,
    parameter int MAX_DECIMATION = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [icda_pkg::SAMPLE_W-1:0]     s_tdata,    // [31:0] sample_word

    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [icda_pkg::M_TDATA_W-1:0]    m_tdata,    // [9:0] channel, [41:10] average
    output logic                              m_tlast,    // frame_last

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [icda_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [icda_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // channel index width
    localparam int PW      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    // frame counter width
    localparam int FW      = (MAX_DECIMATION > 1) ? $clog2(MAX_DECIMATION) : 1;
    // width holding the effective decimation
    localparam int DW      = $clog2(MAX_DECIMATION + 1);
    // divisor 2*d
    localparam int DVW     = DW + 1;
    // compare widths for the clamped channel count and decimation
    localparam int NC_W    = $clog2(MAX_CHANNELS + 1);
    localparam int NCMP_W  = ((NC_W > icda_pkg::NUM_CH_CFG_W) ? NC_W
                                                              : icda_pkg::NUM_CH_CFG_W) + 1;
    localparam int DCMP_W  = ((DW > icda_pkg::DEC_CFG_W) ? DW : icda_pkg::DEC_CFG_W) + 1;

    // configuration
    logic [icda_pkg::NUM_CH_CFG_W-1:0] num_ch_reg;
    logic [icda_pkg::DEC_CFG_W-1:0]    dec_cfg_reg;

    // sequencer
    icda_pkg::state_t state_reg, state_next;

    // stream position
    logic [PW-1:0] position_reg;
    logic [FW-1:0] frame_reg;

    // per-word context
    logic [icda_pkg::SAMPLE_W-1:0] sample_reg;
    logic [PW-1:0]                 ch_reg;
    logic                          last_ch_reg;
    logic                          last_fr_reg;
    logic                          first_reg;
    logic [DW-1:0]                 dec_reg;
    logic                          neg_reg;

    // sum memory
    logic [icda_pkg::SUM_W-1:0] sum_mem [MAX_CHANNELS];
    logic [icda_pkg::SUM_W-1:0] rd_data_reg;
    logic [icda_pkg::SUM_W-1:0] sum_next;

    // output register
    logic                          m_valid_reg;
    logic [icda_pkg::OUT_CH_W-1:0] m_ch_reg;
    logic [icda_pkg::AVG_W-1:0]    m_avg_reg;
    logic                          m_last_reg;

    // effective register values and frame position
    logic [NCMP_W-1:0] n_eff;
    logic [DCMP_W-1:0] d_eff;
    logic              last_ch;
    logic              last_fr;

    // numerator and divider
    logic [icda_pkg::NUM_W-1:0] num;
    logic [icda_pkg::MAG_W-1:0] num_mag;
    logic                       div_start;
    logic                       div_done;
    logic [icda_pkg::MAG_W-1:0] div_quo;
    logic [icda_pkg::AVG_W-1:0] avg_sat;

    logic accept;
    logic out_free;
    logic load_out;

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    // clamp out-of-range register values
    always_comb begin
        if (num_ch_reg == '0) begin
            n_eff = NCMP_W'(1);
        end else if (NCMP_W'(num_ch_reg) > NCMP_W'(MAX_CHANNELS)) begin
            n_eff = NCMP_W'(MAX_CHANNELS);
        end else begin
            n_eff = NCMP_W'(num_ch_reg);
        end
        if (dec_cfg_reg == '0) begin
            d_eff = DCMP_W'(1);
        end else if (DCMP_W'(dec_cfg_reg) > DCMP_W'(MAX_DECIMATION)) begin
            d_eff = DCMP_W'(MAX_DECIMATION);
        end else begin
            d_eff = DCMP_W'(dec_cfg_reg);
        end
        last_ch = (NCMP_W'(position_reg) >= n_eff - 1'b1);
        last_fr = (DCMP_W'(frame_reg) >= d_eff - 1'b1);
    end

    // new running sum and the rounding numerator 2*sum + d
    always_comb begin
        if (first_reg) begin
            sum_next = icda_pkg::SUM_W'($signed(sample_reg));
        end else begin
            sum_next = rd_data_reg + icda_pkg::SUM_W'($signed(sample_reg));
        end
        num = {sum_next[icda_pkg::SUM_W-1], sum_next, 1'b0} + icda_pkg::NUM_W'(dec_reg);
        if (num[icda_pkg::NUM_W-1]) begin
            num_mag = icda_pkg::MAG_W'(-num);
        end else begin
            num_mag = num[icda_pkg::MAG_W-1:0];
        end
    end

    // signed quotient saturated to 32 bits
    always_comb begin
        if (neg_reg) begin
            if ((div_quo[icda_pkg::MAG_W-1:icda_pkg::AVG_W] != '0)
                || (div_quo[icda_pkg::AVG_W-1] && (div_quo[icda_pkg::AVG_W-2:0] != '0))) begin
                avg_sat = {1'b1, {(icda_pkg::AVG_W-1){1'b0}}};
            end else begin
                avg_sat = icda_pkg::AVG_W'(-div_quo[icda_pkg::AVG_W-1:0]);
            end
        end else begin
            if (div_quo[icda_pkg::MAG_W-1:icda_pkg::AVG_W-1] != '0) begin
                avg_sat = {1'b0, {(icda_pkg::AVG_W-1){1'b1}}};
            end else begin
                avg_sat = div_quo[icda_pkg::AVG_W-1:0];
            end
        end
    end

    icda_divider #(
        .DVW (DVW)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (num_mag),
        .divisor  ({dec_reg, 1'b0}),
        .done     (div_done),
        .quotient (div_quo)
    );

    // sequencer: next state and strobes
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        div_start  = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            icda_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = icda_pkg::ST_READ;
                end
            end
            icda_pkg::ST_READ: begin
                if (last_fr_reg) begin
                    div_start  = 1'b1;
                    state_next = icda_pkg::ST_DIV;
                end else begin
                    state_next = icda_pkg::ST_IDLE;
                end
            end
            icda_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = icda_pkg::ST_FIN;
                end
            end
            icda_pkg::ST_FIN: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = icda_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = icda_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= icda_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // config registers and stream position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_ch_reg   <= icda_pkg::NUM_CH_CFG_W'(1);
            dec_cfg_reg  <= icda_pkg::DEC_CFG_W'(1);
            position_reg <= '0;
            frame_reg    <= '0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    icda_pkg::REG_NUM_CHANNELS: begin
                        num_ch_reg <= cfg_data[icda_pkg::NUM_CH_CFG_W-1:0];
                    end
                    icda_pkg::REG_DECIMATION: begin
                        dec_cfg_reg <= cfg_data[icda_pkg::DEC_CFG_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                if (last_ch) begin
                    position_reg <= '0;
                    frame_reg    <= last_fr ? '0 : frame_reg + 1'b1;
                end else begin
                    position_reg <= position_reg + 1'b1;
                end
            end
        end
    end

    // per-word context, latched on the accepted beat; the numerator sign in the read state
    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg  <= s_tdata;
            ch_reg      <= position_reg;
            last_ch_reg <= last_ch;
            last_fr_reg <= last_fr;
            first_reg   <= (frame_reg == '0);
            dec_reg     <= DW'(d_eff);
        end
        if (state_reg == icda_pkg::ST_READ) begin
            neg_reg <= num[icda_pkg::NUM_W-1];
        end
    end

    // sum memory: read on accept, written back in the read state that follows
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_data_reg <= sum_mem[position_reg];
        end
        if (state_reg == icda_pkg::ST_READ) begin
            sum_mem[ch_reg] <= sum_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_ch_reg   <= icda_pkg::OUT_CH_W'(ch_reg);
            m_avg_reg  <= avg_sat;
            m_last_reg <= last_ch_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(icda_pkg::M_TDATA_W - icda_pkg::AVG_W - icda_pkg::OUT_CH_W){1'b0}},
                       m_avg_reg, m_ch_reg};
    assign m_tlast  = m_last_reg;

endmodule

/* test/interleaved_channel_decimating_averager_top_tb.sv */
module interleaved_channel_decimating_averager_top_tb;

    localparam int NUM_CH_MAX   = 1024;
    localparam int DEC_MAX      = 64;
    // allowance for the sequencer to finish its last word, plus margin
    localparam int DRAIN_CYCLES = 60;
    // cycles without any beat on any channel before the run is abandoned
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_WORDS = 500;
    // no idling on either side for this many words at the end
    localparam int CALM_WORDS   = 70;

    localparam longint AVG_MAX = (64'sd1 <<< 31) - 1;
    localparam longint AVG_MIN = -(64'sd1 <<< 31);

    // any index outside the register map, written to show it is ignored
    localparam logic [icda_pkg::CFG_IDX_W-1:0] NO_SUCH_REG = '1;

    // one averaged value as it leaves the block
    typedef struct packed {
        logic [icda_pkg::OUT_CH_W-1:0] channel;
        logic [icda_pkg::AVG_W-1:0]    average;
        logic                          frame_last;
    } avg_beat_t;

    typedef enum logic {
        ROW_WORD,
        ROW_REG
    } row_kind_t;

    // directed stimulus row: a sample word or a register write, with an
    // optional hand-written expectation
    typedef struct packed {
        row_kind_t                        kind;
        logic [icda_pkg::CFG_IDX_W-1:0]   reg_idx;
        logic [icda_pkg::SAMPLE_W-1:0]    value;
        logic                             typed;
        avg_beat_t                        want;
    } stim_row_t;

    logic                               aclk;
    logic                               aresetn   = 1'b0;
    logic                               s_tvalid  = 1'b0;
    logic                               s_tready;
    logic [icda_pkg::SAMPLE_W-1:0]      s_tdata   = '0;
    logic                               m_tvalid;
    logic                               m_tready  = 1'b0;
    logic [icda_pkg::M_TDATA_W-1:0]     m_tdata;
    logic                               m_tlast;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [icda_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [icda_pkg::CFG_DATA_W-1:0]    cfg_data  = '0;

    interleaved_channel_decimating_averager_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // mirror of the block: per-channel sums, cursor and register copies
    logic signed [icda_pkg::SUM_W-1:0]    chan_sum [NUM_CH_MAX];
    logic [icda_pkg::OUT_CH_W-1:0]        next_chan;
    logic [5:0]                           frame_idx;
    logic [icda_pkg::NUM_CH_CFG_W-1:0]    reg_channels;
    logic [icda_pkg::DEC_CFG_W-1:0]       reg_decim;

    avg_beat_t  pending_averages [$];
    stim_row_t  directed_rows [$];
    avg_beat_t  want_beat;
    int         err_count   = 0;
    int         words_sent  = 0;
    int         idle_cycles = 0;
    // idling stops once this many words have been sent
    int         calm_from   = 2147483647;
    bit         calm        = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // register values out of range are clamped, not rejected
    function automatic int clamp_channels(input logic [icda_pkg::NUM_CH_CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > NUM_CH_MAX) return NUM_CH_MAX;
        return int'(v);
    endfunction

    function automatic int clamp_decim(input logic [icda_pkg::DEC_CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > DEC_MAX) return DEC_MAX;
        return int'(v);
    endfunction

    // adds one word into its channel sum and advances the cursor;
    // returns 1 when the word belongs to the last frame of a group
    function automatic bit accumulate_word(input logic [icda_pkg::SAMPLE_W-1:0] word,
                                           output avg_beat_t beat);
        int     n;
        int     d;
        int     ch;
        bit     last_ch;
        bit     last_fr;
        longint num;
        longint q;
        n = clamp_channels(reg_channels);
        d = clamp_decim(reg_decim);
        ch = int'(next_chan);
        // a cursor left beyond a reduced channel count closes the frame
        last_ch = ch >= n - 1;
        // likewise a frame count beyond a reduced decimation closes the group
        last_fr = int'(frame_idx) >= d - 1;
        if (frame_idx == 0)
            chan_sum[ch] = $signed(word);
        else
            chan_sum[ch] = chan_sum[ch] + $signed(word);
        // mean plus one half, truncated toward zero, then saturated
        num = 2 * longint'(chan_sum[ch]) + d;
        q = num / (2 * d);
        if (q > AVG_MAX) q = AVG_MAX;
        if (q < AVG_MIN) q = AVG_MIN;
        beat.channel    = icda_pkg::OUT_CH_W'(ch);
        beat.average    = q[icda_pkg::AVG_W-1:0];
        beat.frame_last = last_ch;
        if (last_ch) begin
            next_chan = '0;
            frame_idx = last_fr ? 6'd0 : frame_idx + 6'd1;
        end else begin
            next_chan = icda_pkg::OUT_CH_W'(ch + 1);
        end
        return last_fr;
    endfunction

    function automatic logic [icda_pkg::SAMPLE_W-1:0] random_word();
        case ($urandom_range(0, 5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return $urandom_range(0, 40) - 20;
            default: return $urandom;
        endcase
    endfunction

    function automatic void note_error(input string msg);
        err_count++;
        if (err_count <= 10) $display("%s", msg);
    endfunction

    function automatic void add_reg(input logic [icda_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [icda_pkg::CFG_DATA_W-1:0] data);
        directed_rows.push_back('{ROW_REG, idx, icda_pkg::SAMPLE_W'(data), 1'b0, '0});
    endfunction

    function automatic void add_word(input logic [icda_pkg::SAMPLE_W-1:0] word);
        directed_rows.push_back('{ROW_WORD, '0, word, 1'b0, '0});
    endfunction

    function automatic void add_checked(input logic [icda_pkg::SAMPLE_W-1:0] word,
                                        input logic [icda_pkg::OUT_CH_W-1:0] ch,
                                        input logic [icda_pkg::AVG_W-1:0] avg,
                                        input logic last);
        avg_beat_t b;
        b.channel    = ch;
        b.average    = avg;
        b.frame_last = last;
        directed_rows.push_back('{ROW_WORD, '0, word, 1'b1, b});
    endfunction

    // one sample beat, with an optional random gap in front of it;
    // tvalid stays high after the beat so back-to-back words need no toggle
    task automatic send_word(input logic [icda_pkg::SAMPLE_W-1:0] word, input bit typed,
                             input avg_beat_t want);
        avg_beat_t beat;
        bit        emits;
        if (words_sent >= calm_from) calm = 1'b1;
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
        emits = accumulate_word(word, beat);
        if (typed)
            pending_averages.push_back(want);
        else if (emits)
            pending_averages.push_back(beat);
    endtask

    // let every expected average come out, then allow for a word still in
    // the sequencer that produces nothing
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_averages.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [icda_pkg::CFG_IDX_W-1:0] idx,
                             input logic [icda_pkg::CFG_DATA_W-1:0] data);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == icda_pkg::REG_NUM_CHANNELS)
            reg_channels = data[icda_pkg::NUM_CH_CFG_W-1:0];
        else if (idx == icda_pkg::REG_DECIMATION)
            reg_decim = data[icda_pkg::DEC_CFG_W-1:0];
    endtask

    // the channel count only changes in the first frame of a group, so that
    // no channel is ever summed before the block has written its entry
    task automatic set_channels(input logic [icda_pkg::CFG_DATA_W-1:0] data);
        while (frame_idx != 0) send_word(random_word(), 1'b0, '0);
        write_reg(icda_pkg::REG_NUM_CHANNELS, data);
    endtask

    // result checker, sampled at the edge so pre-edge values are compared
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_averages.size() == 0) begin
                note_error($sformatf("unexpected beat: channel %0d average %0d last %0b",
                                     m_tdata[9:0], $signed(m_tdata[41:10]), m_tlast));
            end else begin
                want_beat = pending_averages.pop_front();
                if (m_tdata[9:0] !== want_beat.channel)
                    note_error($sformatf("channel: expected %0d, got %0d",
                                         want_beat.channel, m_tdata[9:0]));
                if (m_tdata[41:10] !== want_beat.average)
                    note_error($sformatf("average of channel %0d: expected %0d, got %0d",
                                         want_beat.channel, $signed(want_beat.average),
                                         $signed(m_tdata[41:10])));
                if (m_tlast !== want_beat.frame_last)
                    note_error($sformatf("tlast of channel %0d: expected %0b, got %0b",
                                         want_beat.channel, want_beat.frame_last, m_tlast));
                if (m_tdata[icda_pkg::M_TDATA_W-1:42] !== '0)
                    note_error($sformatf("tdata padding of channel %0d: expected 0, got %h",
                                         want_beat.channel,
                                         m_tdata[icda_pkg::M_TDATA_W-1:42]));
            end
        end
    end

    // watchdog: counts cycles in which no channel moves a beat
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // result side: ready high for random stretches, dropped in bursts
    initial begin
        @(posedge aclk);
        forever begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge aclk);
            if (!calm && $urandom_range(0, 1) == 1) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end
        end
    end

    initial begin
        logic [icda_pkg::CFG_DATA_W-1:0] want_n;
        logic [icda_pkg::CFG_DATA_W-1:0] want_d;
        bit                              write_n;
        bit                              write_d;
        int                              span;
        int                              goal;

        reg_channels = 1;
        reg_decim    = 1;
        next_chan    = '0;
        frame_idx    = '0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset state: one channel, no averaging; a word of zero or above comes out as
        // itself, a negative word one above, as the added half truncates toward zero
        add_checked(32'h0000_0000, 0, 32'h0000_0000, 1'b1);
        add_checked(32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 1'b1);
        add_checked(32'h8000_0000, 0, 32'h8000_0001, 1'b1);
        add_checked(32'hFFFF_FFFF, 0, 32'h0000_0000, 1'b1);
        add_checked(32'h0000_0001, 0, 32'h0000_0001, 1'b1);
        // pairs of extremes: largest sums without wrap
        add_reg(icda_pkg::REG_DECIMATION, 2);
        add_word(32'h7FFF_FFFF);
        add_checked(32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 1'b1);
        add_word(32'h8000_0000);
        add_checked(32'h8000_0000, 0, 32'h8000_0001, 1'b1);
        // three interleaved channels over two frames
        add_reg(icda_pkg::REG_NUM_CHANNELS, 3);
        add_word(10);
        add_word(20);
        add_word(30);
        add_word(11);
        add_word(-21);
        add_word(31);
        // writes outside the map change nothing
        add_reg(NO_SUCH_REG, 11'h7FF);
        // zero registers act as one; decimation keeps only its low 7 bits
        add_reg(icda_pkg::REG_NUM_CHANNELS, 0);
        add_reg(icda_pkg::REG_DECIMATION, 11'h080);
        add_checked(7, 0, 7, 1'b1);
        // cursor left beyond a reduced channel count ends the frame there
        add_reg(icda_pkg::REG_NUM_CHANNELS, 4);
        add_word(100);
        add_word(200);
        add_word(300);
        add_reg(icda_pkg::REG_NUM_CHANNELS, 2);
        add_word(400);
        add_word(500);
        add_word(600);
        // frame count beyond a reduced decimation ends the group there
        add_reg(icda_pkg::REG_NUM_CHANNELS, 1);
        add_reg(icda_pkg::REG_DECIMATION, 4);
        add_word(5);
        add_word(6);
        add_word(-7);
        add_reg(icda_pkg::REG_DECIMATION, 2);
        add_word(9);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_REG)
                write_reg(directed_rows[i].reg_idx,
                          icda_pkg::CFG_DATA_W'(directed_rows[i].value));
            else
                send_word(directed_rows[i].value, directed_rows[i].typed,
                          directed_rows[i].want);
        end

        // a channel count above the maximum acts as the maximum
        set_channels(11'h7FF);
        write_reg(icda_pkg::REG_DECIMATION, 1);
        repeat (24) send_word(random_word(), 1'b0, '0);

        // random phases: mostly whole groups, sometimes a partial run that
        // leaves the cursor mid-frame or mid-group for the next setting
        goal = words_sent + RANDOM_WORDS;
        calm_from = goal - CALM_WORDS;
        while (words_sent < goal) begin
            if ($urandom_range(0, 9) == 0)
                write_reg(icda_pkg::CFG_IDX_W'($urandom_range(2, 255)),
                          icda_pkg::CFG_DATA_W'($urandom));
            write_n = $urandom_range(0, 2) != 0;
            write_d = !write_n || $urandom_range(0, 1) == 1;
            want_n = icda_pkg::CFG_DATA_W'(reg_channels);
            want_d = icda_pkg::CFG_DATA_W'(reg_decim);
            if (write_n) begin
                case ($urandom_range(0, 9))
                    0:       want_n = 0;
                    1:       want_n = $urandom_range(16, 40);
                    default: want_n = $urandom_range(1, 8);
                endcase
            end
            if (write_d) begin
                case ($urandom_range(0, 9))
                    0:       want_d = 0;
                    1:       want_d = DEC_MAX;
                    // upper data bits set, masked away by the register width
                    2:       want_d = {4'($urandom_range(1, 15)), 7'($urandom_range(0, 8))};
                    3:       want_d = $urandom_range(65, 127);
                    default: want_d = $urandom_range(1, 8);
                endcase
            end
            // keep a group short when decimation is large
            if (clamp_channels(want_n[icda_pkg::NUM_CH_CFG_W-1:0])
                    * clamp_decim(want_d[icda_pkg::DEC_CFG_W-1:0]) > 256) begin
                write_n = 1'b1;
                want_n  = $urandom_range(1, 3);
            end
            if (write_n) set_channels(want_n);
            if (write_d) write_reg(icda_pkg::REG_DECIMATION, want_d);
            span = clamp_channels(reg_channels) * clamp_decim(reg_decim);
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, span + 3))
                    if (words_sent < goal) send_word(random_word(), 1'b0, '0);
            end else begin
                repeat (span * $urandom_range(1, 3))
                    if (words_sent < goal) send_word(random_word(), 1'b0, '0);
                while ((next_chan != 0 || frame_idx != 0) && words_sent < goal)
                    send_word(random_word(), 1'b0, '0);
            end
        end

        settle();
        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
